/* hw/rtl/rhc_pkg.sv */
// Shared widths, constants and pipeline word types for the RGB to HSL converter.
`timescale 1ns / 1ps

package rhc_pkg;

  localparam int COMP_W          = 8;
  localparam int HUE_W           = 16;
  localparam int SAT_W           = 17;
  localparam int SUM_W           = COMP_W + 1;
  localparam int HDIV_W          = COMP_W + 3;
  localparam int SDIV_W          = COMP_W;
  localparam int QBITS           = 16;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QBITS / STEPS_PER_STAGE;

  localparam logic [SUM_W-1:0] SUM_FOLD = SUM_W'(2 * (2 ** COMP_W - 1));
  localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(2 ** COMP_W - 1);

  typedef struct packed {
    logic [HDIV_W-1:0] hrem;
    logic [HDIV_W-1:0] hdiv;
    logic [SDIV_W-1:0] srem;
    logic [SDIV_W-1:0] sdiv;
    logic [HUE_W-1:0]  hq;
    logic [SAT_W-1:0]  sq;
    logic [SUM_W-1:0]  sum;
  } div_word_t;

  typedef struct packed {
    logic      valid;
    div_word_t word;
  } div_pipe_t;

endpackage

/* hw/rtl/rhc_in_if.sv */
// Pixel input channel: valid, ready and one RGB word.
`timescale 1ns / 1ps

interface rhc_in_if import rhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

/* hw/rtl/rhc_out_if.sv */
// Result output channel: valid, ready and one HSL word.
`timescale 1ns / 1ps

interface rhc_out_if import rhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [SUM_W-1:0] lightness_sum;

  modport source (output valid, hue, saturation, lightness_sum, input ready);
  modport sink   (input valid, hue, saturation, lightness_sum, output ready);
endinterface

/* hw/rtl/rgb_to_hsl_converter_core.sv */
// Top level: RGB to HSL pixel converter, front end plus pipelined dividers.
// Path from input accept to output valid: the front-end registers, then the DIV_STAGES divider stages.
// Throughput: one word per clock unless the output stalls; each divider stage yields 2 quotient bits per lane.
// A stalled output freezes every stage together, so no word is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_core import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rhc_in_if.sink    in_word,
  rhc_out_if.source out_word
);

  logic      adv;
  div_pipe_t pipe [DIV_STAGES+1];

  assign adv           = !pipe[DIV_STAGES].valid || out_word.ready;
  assign in_word.ready = adv;

  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_word.valid),
    .red      (in_word.red),
    .green    (in_word.green),
    .blue     (in_word.blue),
    .pipe_o   (pipe[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rhc_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .pipe_i (pipe[i]),
      .pipe_o (pipe[i+1])
    );
  end

  assign out_word.valid         = pipe[DIV_STAGES].valid;
  assign out_word.hue           = pipe[DIV_STAGES].word.hq;
  assign out_word.saturation    = pipe[DIV_STAGES].word.sq;
  assign out_word.lightness_sum = pipe[DIV_STAGES].word.sum;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_word.valid)
    else $error("output valid after reset");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_word.valid == $past(pipe[DIV_STAGES-1].valid))
    else $error("valid bit lost or invented in last stage");

  a_sat_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.saturation[SAT_W-1] |-> out_word.saturation[SAT_W-2:0] == '0)
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.lightness_sum == '0 |->
      out_word.hue == '0 && out_word.saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

endmodule

/* hw/rtl/rhc_front.sv */
// Front end: max/min, hue numerator and divisors, then first saturation quotient bit.
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output div_pipe_t         pipe_o
);

  logic              r_max;
  logic              g_max;
  logic [COMP_W-1:0] mx;
  logic [COMP_W-1:0] mn;
  logic [COMP_W-1:0] d;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  fold;
  logic              grey;
  logic [HDIV_W-1:0] rx, gx, bx, dx, d6;
  logic [HDIV_W-1:0] num;
  logic [SDIV_W-1:0] den;

  logic              valid1_r;
  logic [HDIV_W-1:0] num_r, hdiv_r;
  logic [COMP_W-1:0] d_r;
  logic [SDIV_W-1:0] sdiv_r;
  logic [SUM_W-1:0]  sum_r;

  logic              q_top;
  div_word_t         word_nxt;
  div_pipe_t         pipe_r;

  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = (green >= blue);
    priority if (r_max) begin
      mx = red;
    end else if (g_max) begin
      mx = green;
    end else begin
      mx = blue;
    end
    mn   = (red <= green) ? ((red <= blue) ? red : blue) : ((green <= blue) ? green : blue);
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    fold = SUM_FOLD - sum;
    grey = (d == '0);
    rx   = HDIV_W'(red);
    gx   = HDIV_W'(green);
    bx   = HDIV_W'(blue);
    dx   = HDIV_W'(d);
    d6   = (dx << 2) + (dx << 1);
    priority if (r_max) begin
      num = (green >= blue) ? (gx - bx) : (d6 - (bx - gx));
    end else if (g_max) begin
      num = (dx << 1) + bx - rx;
    end else begin
      num = (dx << 2) + rx - gx;
    end
    den = (sum <= SUM_HALF) ? sum[SDIV_W-1:0] : fold[SDIV_W-1:0];
  end

  // grey pixels get unit divisors so both quotients come out zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
    end
    if (en) begin
      num_r  <= grey ? '0 : num;
      hdiv_r <= grey ? HDIV_W'(1) : d6;
      d_r    <= d;
      sdiv_r <= grey ? SDIV_W'(1) : den;
      sum_r  <= sum;
    end
  end

  always_comb begin
    q_top         = (d_r >= sdiv_r);
    word_nxt.hrem = num_r;
    word_nxt.hdiv = hdiv_r;
    word_nxt.srem = q_top ? (d_r - sdiv_r) : d_r;
    word_nxt.sdiv = sdiv_r;
    word_nxt.hq   = '0;
    word_nxt.sq   = {{(SAT_W-1){1'b0}}, q_top};
    word_nxt.sum  = sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r.valid <= valid1_r;
    end
    if (en) begin
      pipe_r.word <= word_nxt;
    end
  end

  assign pipe_o = pipe_r;

endmodule

/* hw/rtl/rhc_div_stage.sv */
// One divider stage: STEPS_PER_STAGE restoring steps on the hue and saturation lanes.
`timescale 1ns / 1ps

module rhc_div_stage import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  div_pipe_t pipe_i,
  output div_pipe_t pipe_o
);

  div_word_t       w;
  logic [HDIV_W:0] ht;
  logic [SDIV_W:0] st;
  div_pipe_t       pipe_r;

  always_comb begin
    w  = pipe_i.word;
    ht = '0;
    st = '0;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      ht = {w.hrem, 1'b0};
      if (ht >= {1'b0, w.hdiv}) begin
        w.hrem = HDIV_W'(ht - {1'b0, w.hdiv});
        w.hq   = {w.hq[HUE_W-2:0], 1'b1};
      end else begin
        w.hrem = ht[HDIV_W-1:0];
        w.hq   = {w.hq[HUE_W-2:0], 1'b0};
      end
      st = {w.srem, 1'b0};
      if (st >= {1'b0, w.sdiv}) begin
        w.srem = SDIV_W'(st - {1'b0, w.sdiv});
        w.sq   = {w.sq[SAT_W-2:0], 1'b1};
      end else begin
        w.srem = st[SDIV_W-1:0];
        w.sq   = {w.sq[SAT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else if (en) begin
      pipe_r.valid <= pipe_i.valid;
    end
    if (en) begin
      pipe_r.word <= w;
    end
  end

  assign pipe_o = pipe_r;

endmodule
